>>> hw/rtl/apf_pkg.sv
// Shared types and constants for the anagram pair finder.
package apf_pkg;

    localparam int ALPHABET      = 26;
    localparam int CNT_W         = 7;
    localparam int POS_W         = 7;
    localparam int IDX_OUT_W     = 6;
    localparam int TOT_W         = 12;
    localparam int TOT_OUT_W     = 11;
    localparam int DEF_MAX_CHARS = 128;
    localparam int DEF_MAX_WORDS = 64;

    localparam logic [CNT_W-1:0] CNT_SAT   = 7'd127;
    localparam logic [TOT_W-1:0] TOT_SAT   = 12'd4095;
    localparam logic [7:0]       CH_UA     = 8'h41;
    localparam logic [7:0]       CH_UZ     = 8'h5A;
    localparam logic [7:0]       CH_LA     = 8'h61;
    localparam logic [7:0]       CH_LZ     = 8'h7A;
    localparam logic [7:0]       CASE_FOLD = 8'd32;

    typedef struct packed {
        logic [POS_W-1:0]               start;
        logic [CNT_W-1:0]               length;
        logic [ALPHABET-1:0][CNT_W-1:0] counts;
    } word_t;

    typedef struct packed {
        logic                 kind;
        logic [IDX_OUT_W-1:0] word_a;
        logic [IDX_OUT_W-1:0] word_b;
        logic [POS_W-1:0]     start_a;
        logic [CNT_W-1:0]     length_a;
        logic [POS_W-1:0]     start_b;
        logic [CNT_W-1:0]     length_b;
        logic [TOT_OUT_W-1:0] total;
        logic                 overflow;
    } result_t;

    typedef struct packed {
        logic       update;
        logic       fresh;
        logic [4:0] letter;
        logic [POS_W-1:0] start;
    } hist_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STORE,
        ST_FLUSH,
        ST_SUMM
    } state_t;

    localparam logic KIND_PAIR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

endpackage

>>> hw/rtl/anagram_pair_finder.sv
// Anagram pair finder: ring of stored word cells and the control around it.
// Flow: a letter or separator that ends no word is taken in idle; a word end
// runs scan over one full turn of the word-cell ring, then store, then flush.
// End of line: the summary state sends any held pair first, then the summary;
// it is entered from idle when no word is to be stored, or else after store.
// Input: one character at a time; s_ready is high only in idle.
// Reset: synchronous active-low aresetn clears control and sentence state;
// the word cells need no reset since only written cells are compared.
module anagram_pair_finder
    import apf_pkg::*;
#(
    parameter int MAX_CHARS = DEF_MAX_CHARS,
    parameter int MAX_WORDS = DEF_MAX_WORDS
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_code,
    input  logic                 s_end_of_line,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_record_kind,
    output logic [IDX_OUT_W-1:0] m_word_a,
    output logic [IDX_OUT_W-1:0] m_word_b,
    output logic [POS_W-1:0]     m_start_a,
    output logic [CNT_W-1:0]     m_length_a,
    output logic [POS_W-1:0]     m_start_b,
    output logic [CNT_W-1:0]     m_length_b,
    output logic [TOT_OUT_W-1:0] m_total_pairs,
    output logic                 m_overflow,
    output logic                 m_last
);

    localparam int PW  = $clog2(MAX_CHARS + 1);
    localparam int SW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WCW = $clog2(MAX_WORDS + 1);

    state_t state_reg, state_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic           inside_reg, inside_next;
    logic [WCW-1:0] wc_reg, wc_next;
    logic [SW-1:0]  step_reg, step_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic           drop_reg, drop_next;
    logic           eol_reg, eol_next;
    logic           hold_valid_reg, hold_valid_next;
    result_t        hold_reg, hold_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_last_reg, out_last_next;
    result_t        out_reg, out_next;

    hist_ctl_t hctl;
    word_t     cur_word;
    logic      match;
    logic      shift_en;
    logic      store_en;
    word_t     cell_q [MAX_WORDS];

    // Ring of word cells: each cell takes its upper neighbor on a shift, so
    // after s shifts cell 0 holds word s and a full turn restores the order.
    for (genvar k = 0; k < MAX_WORDS; k++) begin : g_cell
        apf_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .load_en  (store_en && (wc_reg == WCW'(k))),
            .shift_in (cell_q[(k + 1) % MAX_WORDS]),
            .load_in  (cur_word),
            .word_q   (cell_q[k])
        );
    end

    apf_hist u_hist (
        .aclk     (aclk),
        .ctl      (hctl),
        .cmp_word (cell_q[0]),
        .cur_word (cur_word),
        .match    (match)
    );

    logic [7:0] folded;
    logic       is_letter;
    logic       out_free;
    logic       match_eff;
    logic       finish;
    logic [TOT_W-1:0] tot_inc;

    always_comb begin
        folded    = ((s_char_code >= CH_UA) && (s_char_code <= CH_UZ)) ?
                    s_char_code + CASE_FOLD : s_char_code;
        is_letter = (folded >= CH_LA) && (folded <= CH_LZ);
        out_free  = !out_valid_reg || m_ready;
        match_eff = match && (WCW'(step_reg) < wc_reg);
        tot_inc   = (tot_reg != TOT_SAT) ? tot_reg + 1'b1 : tot_reg;
        finish    = 1'b0;

        state_next      = state_reg;
        pos_next        = pos_reg;
        inside_next     = inside_reg;
        wc_next         = wc_reg;
        step_next       = step_reg;
        tot_next        = tot_reg;
        drop_next       = drop_reg;
        eol_next        = eol_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_last_next   = out_last_reg;
        out_next        = out_reg;
        hctl            = '0;
        hctl.letter     = 5'(folded - CH_LA);
        hctl.start      = POS_W'(pos_reg);
        shift_en        = 1'b0;
        store_en        = 1'b0;
        s_ready         = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    eol_next = s_end_of_line;
                    if (pos_reg < PW'(MAX_CHARS)) begin
                        pos_next = pos_reg + 1'b1;
                        if (is_letter) begin
                            hctl.update = 1'b1;
                            hctl.fresh  = !inside_reg;
                            inside_next = 1'b1;
                            finish      = s_end_of_line;
                        end else begin
                            finish = inside_reg;
                        end
                    end else begin
                        drop_next = 1'b1;
                        finish    = s_end_of_line && inside_reg;
                    end
                    if (finish) begin
                        inside_next = 1'b0;
                        if (wc_reg >= WCW'(MAX_WORDS)) begin
                            drop_next  = 1'b1;
                            state_next = s_end_of_line ? ST_SUMM : ST_IDLE;
                        end else begin
                            step_next  = '0;
                            state_next = ST_SCAN;
                        end
                    end else if (s_end_of_line) begin
                        state_next = ST_SUMM;
                    end
                end
            end
            ST_SCAN: begin
                // advance unless a new pair must displace a held one that
                // cannot yet move into the output register
                if (!(match_eff && hold_valid_reg && !out_free)) begin
                    shift_en  = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (match_eff) begin
                        tot_next           = tot_inc;
                        hold_valid_next    = 1'b1;
                        hold_next.kind     = KIND_PAIR;
                        hold_next.word_a   = IDX_OUT_W'(step_reg);
                        hold_next.word_b   = IDX_OUT_W'(wc_reg);
                        hold_next.start_a  = cell_q[0].start;
                        hold_next.length_a = cell_q[0].length;
                        hold_next.start_b  = cur_word.start;
                        hold_next.length_b = cur_word.length;
                        hold_next.total    = TOT_OUT_W'(tot_inc);
                        hold_next.overflow = drop_reg;
                        if (hold_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                            out_next       = hold_reg;
                        end
                    end
                    if (step_reg == SW'(MAX_WORDS - 1)) begin
                        state_next = ST_STORE;
                    end
                end
            end
            ST_STORE: begin
                store_en   = 1'b1;
                wc_next    = wc_reg + 1'b1;
                state_next = eol_reg ? ST_SUMM : ST_FLUSH;
            end
            ST_FLUSH: begin
                // the held pair is the final result of this character
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_next        = hold_reg;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_SUMM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (hold_valid_reg) begin
                        out_last_next   = 1'b0;
                        out_next        = hold_reg;
                        hold_valid_next = 1'b0;
                    end else begin
                        out_last_next     = 1'b1;
                        out_next          = '0;
                        out_next.kind     = KIND_SUMMARY;
                        out_next.total    = TOT_OUT_W'(tot_reg);
                        out_next.overflow = drop_reg;
                        // drop all sentence state
                        pos_next    = '0;
                        inside_next = 1'b0;
                        wc_next     = '0;
                        tot_next    = '0;
                        drop_next   = 1'b0;
                        eol_next    = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            inside_reg     <= 1'b0;
            wc_reg         <= '0;
            step_reg       <= '0;
            tot_reg        <= '0;
            drop_reg       <= 1'b0;
            eol_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            inside_reg     <= inside_next;
            wc_reg         <= wc_next;
            step_reg       <= step_next;
            tot_reg        <= tot_next;
            drop_reg       <= drop_next;
            eol_reg        <= eol_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_record_kind = out_reg.kind;
    assign m_word_a      = out_reg.word_a;
    assign m_word_b      = out_reg.word_b;
    assign m_start_a     = out_reg.start_a;
    assign m_length_a    = out_reg.length_a;
    assign m_start_b     = out_reg.start_b;
    assign m_length_b    = out_reg.length_b;
    assign m_total_pairs = out_reg.total;
    assign m_overflow    = out_reg.overflow;
    assign m_last        = out_last_reg;

`ifndef SYNTH
    a_idle_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held pair left behind in idle");
    a_wc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wc_reg <= WCW'(MAX_WORDS))
        else $error("word count past capacity");
    a_store_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STORE) |-> (wc_reg < WCW'(MAX_WORDS)))
        else $error("store with ring full");
    a_pairs_need_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (tot_reg != '0) |-> (wc_reg >= WCW'(1)))
        else $error("pair counted without stored words");
`endif

endmodule

>>> hw/rtl/apf_cell.sv
// One stored word of the ring: shifts toward its neighbor or loads a new word.
module apf_cell
    import apf_pkg::*;
(
    input  logic  aclk,
    input  logic  shift_en,
    input  logic  load_en,
    input  word_t shift_in,
    input  word_t load_in,
    output word_t word_q
);

    word_t word_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            word_reg <= shift_in;
        end else if (load_en) begin
            word_reg <= load_in;
        end
    end

    assign word_q = word_reg;

endmodule

>>> hw/rtl/apf_hist.sv
// Current word builder: letter histogram, length, start, and match compare.
module apf_hist
    import apf_pkg::*;
(
    input  logic      aclk,
    input  hist_ctl_t ctl,
    input  word_t     cmp_word,
    output word_t     cur_word,
    output logic      match
);

    word_t cur_reg;
    word_t cur_next;

    always_comb begin
        cur_next = cur_reg;
        if (ctl.update) begin
            if (ctl.fresh) begin
                cur_next.start  = ctl.start;
                cur_next.length = '0;
                cur_next.counts = '0;
            end
            if (cur_next.counts[ctl.letter] != CNT_SAT) begin
                cur_next.counts[ctl.letter] = cur_next.counts[ctl.letter] + 1'b1;
            end
            if (cur_next.length != CNT_SAT) begin
                cur_next.length = cur_next.length + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    assign cur_word = cur_reg;
    assign match    = (cmp_word.length == cur_reg.length) &&
                      (cmp_word.counts == cur_reg.counts);

endmodule
